/* hdl/potential_field_force_map_assert.svh */
// Assertion helpers shared by the force map RTL.
`ifndef POTENTIAL_FIELD_FORCE_MAP_ASSERT_SVH
`define POTENTIAL_FIELD_FORCE_MAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFFM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/pffm_pkg.sv */
package pffm_pkg;

   // Commands carried on the request tuser.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_TARGET_ROW = 3'd0;
   localparam logic [2:0] REG_TARGET_COL = 3'd1;
   localparam logic [2:0] REG_ATTRACT    = 3'd2;
   localparam logic [2:0] REG_REPEL      = 3'd3;
   localparam logic [2:0] REG_RADIUS     = 3'd4;

   // Iteration counts of the bit-serial square root and the shared bit-serial divider.
   localparam int SQRT_STEPS = 24;
   localparam int DIV_STEPS  = 17;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INVR,
      ST_READ,
      ST_DIST,
      ST_SQRT,
      ST_DIV,
      ST_CUBE1,
      ST_CUBE2,
      ST_MAG,
      ST_GAIN,
      ST_TROW,
      ST_TCOL,
      ST_DONE
   } state_type;

endpackage

/* hdl/potential_field_force_map.sv */
// Potential-field force map. Obstacle cells are loaded into an on-chip list (command load),
// the list is emptied by command clear, and command query returns one result beat holding
// the attractive plus repulsive force on the queried cell as signed Q23.8, saturated.
// A query runs an accept, a bit-serial reciprocal of the influence radius and a result load,
// plus a walk over every stored obstacle: a read and a distance step for an obstacle outside
// the radius or on the cell, and for one inside it also the bit-serial square root, the
// bit-serial reciprocal and six multiply stages that share one sequencer. The obstacle list
// is one synchronous memory read once per obstacle; it needs no clearing pass after reset.
// A new request beat is taken only when the sequencer is idle; a finished result waits in
// the output register while loads and clears continue to be accepted.
module potential_field_force_map #(
   parameter int MAX_OBSTACLES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [7:0] cell_row, [15:8] cell_col
   input  logic [1:0]  req_tuser,    // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [31:0] force_row, [63:32] force_col
   output logic [1:0]  rsp_tuser,    // [0] on_obstacle, [1] obstacles_dropped
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pffm_pkg::*;
`include "potential_field_force_map_assert.svh"

   localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
   localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int KW    = IDX_W + 1;
   // Each repulsive term stays below 2^24, the attractive part below 2^33.
   localparam int ACC_W = CNT_W + 35;

   // Configuration registers.
   logic [7:0]  target_row_ff, target_col_ff, radius_ff;
   logic [23:0] attract_ff;
   logic [15:0] repel_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_row_ff <= 8'd16;
         target_col_ff <= 8'd178;
         attract_ff    <= 24'd230400;
         repel_ff      <= 16'd1280;
         radius_ff     <= 8'd20;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_TARGET_ROW: target_row_ff <= csr_pwdata[7:0];
            REG_TARGET_COL: target_col_ff <= csr_pwdata[7:0];
            REG_ATTRACT:    attract_ff    <= csr_pwdata[23:0];
            REG_REPEL:      repel_ff      <= csr_pwdata[15:0];
            REG_RADIUS:     radius_ff     <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_TARGET_ROW: csr_prdata = {24'd0, target_row_ff};
         REG_TARGET_COL: csr_prdata = {24'd0, target_col_ff};
         REG_ATTRACT:    csr_prdata = {8'd0, attract_ff};
         REG_REPEL:      csr_prdata = {16'd0, repel_ff};
         REG_RADIUS:     csr_prdata = {24'd0, radius_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // Sequencer and datapath registers.
   state_type               state_ff, state_in;
   logic [4:0]              step_ff, step_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    dropped_ff, dropped_in;
   logic                    hit_ff, hit_in;
   logic [7:0]              qrow_ff, qrow_in, qcol_ff, qcol_in;
   logic signed [ACC_W-1:0] acc_r_ff, acc_r_in, acc_c_ff, acc_c_in;
   logic [15:0]             obs_q_ff;
   logic signed [8:0]       dr_ff, dr_in, dc_ff, dc_in;
   logic [15:0]             xsh_ff, xsh_in;
   logic [23:0]             root_ff, root_in;
   logic [24:0]             srem_ff, srem_in;
   logic [23:0]             drem_ff, drem_in;
   logic [16:0]             quot_ff, quot_in;
   logic [16:0]             inv_r_ff, inv_r_in, inv_d_ff, inv_d_in;
   logic [17:0]             t1_ff, t1_in;
   logic [18:0]             inv_d3_ff, inv_d3_in;
   logic [19:0]             mag_ff, mag_in;
   logic [35:0]             gm_ff, gm_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [63:0]             rsp_data_ff, rsp_data_in;
   logic [1:0]              rsp_user_ff, rsp_user_in;

   logic [15:0] obstacle_mem [MAX_OBSTACLES];

   logic req_acc, out_free, last_obs, mem_wr, in_range, div_bring, div_ge, sqrt_ge;
   logic signed [8:0]  off_r, off_c;
   logic signed [33:0] att_r, att_c;
   logic [17:0] d2;
   logic [15:0] rad2;
   logic [23:0] divisor;
   logic [24:0] drem_sh, drem_nx;
   logic [26:0] srem_sh, trial, srem_nx;
   logic [16:0] diff;
   logic [33:0] p_sq;
   logic [34:0] p_cube;
   logic [35:0] p_mag;
   logic [7:0]  abs_off;
   logic signed [8:0] off_sel;
   logic [43:0] p_term;
   logic signed [ACC_W-1:0] term_s, acc_sel;
   logic [31:0] sat_r, sat_c;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_obs   = (KW'(k_ff) + KW'(1)) == KW'(count_ff);
   assign mem_wr     = req_acc && (req_tuser == CMD_LOAD) &&
                       (count_ff < CNT_W'(MAX_OBSTACLES));

   // Distance of the current obstacle.
   assign d2 = 18'(dr_in * dr_in) + 18'(dc_in * dc_in);
   assign rad2 = 16'(radius_ff * radius_ff);
   assign in_range = (d2 != 18'd0) && (d2 < {2'b00, rad2});

   // Shared restoring divider: 2^16 / radius first, then 2^32 / sqrt per obstacle.
   assign div_bring = (state_ff == ST_INVR) && (step_ff == 5'd0);
   assign divisor   = (state_ff == ST_INVR) ? {16'd0, radius_ff} : root_ff;
   assign drem_sh   = {drem_ff, div_bring};
   assign div_ge    = drem_sh >= {1'b0, divisor};
   assign drem_nx   = div_ge ? drem_sh - {1'b0, divisor} : drem_sh;

   // Digit-by-digit square root of d2 * 2^32, two radicand bits a step.
   assign srem_sh = {srem_ff, xsh_ff[15:14]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign sqrt_ge = srem_sh >= trial;
   assign srem_nx = sqrt_ge ? srem_sh - trial : srem_sh;

   assign diff   = (inv_d_ff > inv_r_ff) ? inv_d_ff - inv_r_ff : 17'd0;
   assign p_sq   = inv_d_ff * inv_d_ff;
   assign p_cube = t1_ff * inv_d_ff;
   assign p_mag  = diff * inv_d3_ff;

   // One signed term per cycle, row then column; truncation toward zero.
   assign off_sel = (state_ff == ST_TROW) ? dr_ff : dc_ff;
   assign abs_off = off_sel[8] ? 8'(-off_sel) : off_sel[7:0];
   assign p_term  = gm_ff * abs_off;
   assign term_s  = off_sel[8] ? -ACC_W'({1'b0, p_term[43:16]})
                               : ACC_W'({1'b0, p_term[43:16]});
   assign acc_sel = (state_ff == ST_TROW) ? acc_r_ff : acc_c_ff;

   assign off_r = $signed({1'b0, req_tdata[7:0]}) - $signed({1'b0, target_row_ff});
   assign off_c = $signed({1'b0, req_tdata[15:8]}) - $signed({1'b0, target_col_ff});
   assign att_r = $signed({10'd0, attract_ff}) * off_r;
   assign att_c = $signed({10'd0, attract_ff}) * off_c;

   // Saturate when the bits above the sign of a 32-bit word disagree.
   assign sat_r = (&acc_r_ff[ACC_W-1:31] || ~|acc_r_ff[ACC_W-1:31]) ? acc_r_ff[31:0] :
                  (acc_r_ff[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
   assign sat_c = (&acc_c_ff[ACC_W-1:31] || ~|acc_c_ff[ACC_W-1:31]) ? acc_c_ff[31:0] :
                  (acc_c_ff[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc && req_tuser == CMD_QUERY) state_in = ST_INVR;
         ST_INVR: begin
            if (step_ff == 5'(DIV_STEPS - 1))
               state_in = (count_ff == '0) ? ST_DONE : ST_READ;
         end
         ST_READ:  state_in = ST_DIST;
         ST_DIST: begin
            if (in_range) state_in = ST_SQRT;
            else          state_in = last_obs ? ST_DONE : ST_READ;
         end
         ST_SQRT:  if (step_ff == 5'(SQRT_STEPS - 1)) state_in = ST_DIV;
         ST_DIV:   if (step_ff == 5'(DIV_STEPS - 1)) state_in = ST_CUBE1;
         ST_CUBE1: state_in = ST_CUBE2;
         ST_CUBE2: state_in = ST_MAG;
         ST_MAG:   state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_TROW;
         ST_TROW:  state_in = ST_TCOL;
         ST_TCOL:  state_in = last_obs ? ST_DONE : ST_READ;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      step_in   = (state_in != state_ff) ? 5'd0 : step_ff + 5'd1;
      k_in      = k_ff;
      count_in  = count_ff;
      dropped_in = dropped_ff;
      hit_in    = hit_ff;
      qrow_in   = qrow_ff;
      qcol_in   = qcol_ff;
      acc_r_in  = acc_r_ff;
      acc_c_in  = acc_c_ff;
      dr_in     = $signed({1'b0, qrow_ff}) - $signed({1'b0, obs_q_ff[7:0]});
      dc_in     = $signed({1'b0, qcol_ff}) - $signed({1'b0, obs_q_ff[15:8]});
      xsh_in    = xsh_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      drem_in   = drem_ff;
      quot_in   = quot_ff;
      inv_r_in  = inv_r_ff;
      inv_d_in  = inv_d_ff;
      t1_in     = t1_ff;
      inv_d3_in = inv_d3_ff;
      mag_in    = mag_ff;
      gm_in     = gm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_tuser)
                  CMD_LOAD: begin
                     if (mem_wr) count_in = count_ff + CNT_W'(1);
                     else        dropped_in = 1'b1;
                  end
                  CMD_QUERY: begin
                     qrow_in  = req_tdata[7:0];
                     qcol_in  = req_tdata[15:8];
                     acc_r_in = -ACC_W'(att_r);
                     acc_c_in = -ACC_W'(att_c);
                     hit_in   = 1'b0;
                     k_in     = '0;
                     drem_in  = '0;
                     quot_in  = '0;
                  end
                  CMD_CLEAR: begin
                     count_in   = '0;
                     dropped_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_INVR: begin
            drem_in = drem_nx[23:0];
            quot_in = {quot_ff[15:0], div_ge};
            inv_r_in = {quot_ff[15:0], div_ge};
         end
         ST_DIST: begin
            if (d2 == 18'd0) hit_in = 1'b1;
            if (in_range) begin
               xsh_in  = d2[15:0];
               root_in = '0;
               srem_in = '0;
            end else if (!last_obs) begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_SQRT: begin
            xsh_in  = {xsh_ff[13:0], 2'b00};
            srem_in = srem_nx[24:0];
            root_in = {root_ff[22:0], sqrt_ge};
            drem_in = 24'h00_8000;
            quot_in = '0;
         end
         ST_DIV: begin
            drem_in  = drem_nx[23:0];
            quot_in  = {quot_ff[15:0], div_ge};
            inv_d_in = {quot_ff[15:0], div_ge};
         end
         ST_CUBE1: t1_in = p_sq[33:16];
         ST_CUBE2: inv_d3_in = p_cube[34:16];
         ST_MAG:   mag_in = p_mag[35:16];
         ST_GAIN:  gm_in = repel_ff * mag_ff;
         ST_TROW:  acc_r_in = acc_sel + term_s;
         ST_TCOL: begin
            acc_c_in = acc_sel + term_s;
            if (!last_obs) k_in = k_ff + IDX_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hit_ff ? 64'd0 : {sat_c, sat_r};
               rsp_user_in  = {dropped_ff, hit_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      hit_ff      <= hit_in;
      qrow_ff     <= qrow_in;
      qcol_ff     <= qcol_in;
      acc_r_ff    <= acc_r_in;
      acc_c_ff    <= acc_c_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      xsh_ff      <= xsh_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      drem_ff     <= drem_in;
      quot_ff     <= quot_in;
      inv_r_ff    <= inv_r_in;
      inv_d_ff    <= inv_d_in;
      t1_ff       <= t1_in;
      inv_d3_ff   <= inv_d3_in;
      mag_ff      <= mag_in;
      gm_ff       <= gm_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Obstacle list: column in the upper byte, row in the lower byte.
   always_ff @(posedge clock) begin
      if (mem_wr) obstacle_mem[count_ff[IDX_W-1:0]] <= req_tdata;
      obs_q_ff <= obstacle_mem[k_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `PFFM_ASSERT_SAME(a_count_cap, clock, reset, 1'b1,
      count_ff <= CNT_W'(MAX_OBSTACLES), "obstacle count beyond capacity")
   `PFFM_ASSERT_NEXT(a_query_start, clock, reset, req_acc && req_tuser == CMD_QUERY,
      state_ff == ST_INVR, "query did not start the radius reciprocal")
   `PFFM_ASSERT_SAME(a_root_floor, clock, reset, state_ff == ST_DIV,
      root_ff >= 24'h01_0000, "root of an in-range obstacle below one cell")
   `PFFM_ASSERT_NEXT(a_rsp_load, clock, reset, state_ff == ST_DONE && out_free,
      rsp_valid_ff && state_ff == ST_IDLE, "finished query did not reach the output register")

endmodule
